/* rtl/assert_macros.svh */
// assertion macros shared by the tokenizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock outside reset
`define QT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define QT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/qtok_pkg.sv */
// types, constants and byte classes for the query tokenizer
`timescale 1ns / 1ps

package qtok_pkg;

    // scan state of the tokenizer
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_TRAIL,
        MODE_GAP
    } mode_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MAX_WORD_CHARS = 2'd0,
        REG_MAX_RUN_BYTES  = 2'd1
    } reg_index_t;

    localparam logic [7:0] LEAD_LO   = 8'hB0;
    localparam logic [7:0] LEAD_HI   = 8'hF7;
    localparam logic [7:0] TRAIL_LO  = 8'hA1;
    localparam logic [7:0] TRAIL_HI  = 8'hFE;
    localparam logic [7:0] HIGH_MIN  = 8'h80;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] RUN_CAP   = 8'd254;

    localparam logic [5:0] MAX_WORD_CHARS_RST = 6'd10;
    localparam logic [7:0] MAX_RUN_BYTES_RST  = 8'd100;

    // one query byte with its flags
    typedef struct packed {
        logic [7:0] query_byte;
        logic       search_started;
        logic       end_of_query;
    } item_t;

    // one search token
    typedef struct packed {
        logic        token_kind;
        logic [15:0] token_start;
        logic [7:0]  token_length;
        logic        excluded;
        logic        query_done;
    } token_t;

    // configuration register contents
    typedef struct packed {
        logic [5:0] max_word_chars;
        logic [7:0] max_run_bytes;
    } cfg_t;

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_lead(input logic [7:0] b);
        return (b >= LEAD_LO) && (b <= LEAD_HI);
    endfunction

    function automatic logic is_trail(input logic [7:0] b);
        return (b >= TRAIL_LO) && (b <= TRAIL_HI);
    endfunction

endpackage

/* rtl/qtok_in_reg.sv */
// input register stage for query bytes
`timescale 1ns / 1ps

module qtok_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             query_valid,
    output logic             query_stall,
    input  qtok_pkg::item_t  item,
    input  logic             take,
    output logic             held_valid,
    output qtok_pkg::item_t  held_item
);

    logic            valid_reg;
    logic            valid_next;
    qtok_pkg::item_t item_reg;
    logic            load;

    // register is free when empty or being drained this cycle
    assign load        = !valid_reg || take;
    assign query_stall = !load;
    assign valid_next  = load ? query_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load && query_valid)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

/* rtl/qtok_step.sv */
// tokenizer state and per-byte next-state logic
`timescale 1ns / 1ps

module qtok_step #(
    parameter int POS_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  qtok_pkg::cfg_t   cfg,
    input  logic             item_valid,
    input  qtok_pkg::item_t  item,
    output logic             res_valid,
    output qtok_pkg::token_t res
);

    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

    qtok_pkg::mode_t     mode_reg, mode_next;
    logic [7:0]          tok_reg, tok_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic                space_reg, space_next;
    logic                excl_reg, excl_next;
    logic                skip_reg, skip_next;
    logic                stop_reg, stop_next;

    logic [7:0]            b;
    logic                  eoq;
    logic [7:0]            run_limit;
    logic [POS_BITS-1:0]   here;
    logic                  brk;
    logic                  emit_req;
    logic                  emit_done;
    logic                  tl_req;
    logic                  tl_eoq;
    logic                  clr;
    logic                  hit;
    logic                  kind;
    logic [7:0]            len;
    logic                  ex;
    logic                  done;
    logic [POS_BITS-1:0]   start_sel;
    logic [POS_BITS+15:0]  start_ext;

    assign b         = item.query_byte;
    assign eoq       = item.end_of_query;
    assign run_limit = (cfg.max_run_bytes > qtok_pkg::RUN_CAP) ? qtok_pkg::RUN_CAP
                                                               : cfg.max_run_bytes;
    assign here      = pos_reg;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= qtok_pkg::MODE_IDLE;
            tok_reg   <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
            space_reg <= 1'b0;
            excl_reg  <= 1'b0;
            skip_reg  <= 1'b0;
            stop_reg  <= 1'b0;
        end
        else if (item_valid)
        begin
            mode_reg  <= mode_next;
            tok_reg   <= tok_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            space_reg <= space_next;
            excl_reg  <= excl_next;
            skip_reg  <= skip_next;
            stop_reg  <= stop_next;
        end
    end

    // next state and token for the byte in the input register
    always_comb
    begin
        mode_next  = mode_reg;
        tok_next   = tok_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        space_next = space_reg;
        excl_next  = excl_reg;
        skip_next  = skip_reg;
        stop_next  = stop_reg;
        brk        = 1'b0;
        emit_req   = 1'b0;
        emit_done  = 1'b0;
        tl_req     = 1'b0;
        tl_eoq     = 1'b0;
        clr        = 1'b0;
        hit        = 1'b0;
        kind       = 1'b0;
        len        = '0;
        ex         = 1'b0;
        done       = 1'b0;
        start_sel  = start_reg;

        // main scan of one byte
        if (stop_reg)
        begin
            clr = eoq;
        end
        else if (skip_reg)
        begin
            skip_next = 1'b0;
            if (eoq)
            begin
                clr = 1'b1;
            end
            else if (b == qtok_pkg::CH_NUL)
            begin
                stop_next = 1'b1;
            end
        end
        else
        begin
            pos_next = pos_reg + POS_ONE;
            if (mode_reg == qtok_pkg::MODE_IDLE)
            begin
                if (b == qtok_pkg::CH_NUL)
                begin
                    if (eoq)
                    begin
                        clr = 1'b1;
                    end
                    else
                    begin
                        stop_next = 1'b1;
                    end
                end
                else
                begin
                    tl_req = 1'b1;
                    tl_eoq = eoq;
                end
            end
            else if (b == qtok_pkg::CH_NUL)
            begin
                emit_req  = 1'b1;
                emit_done = 1'b1;
                if (eoq)
                begin
                    clr = 1'b1;
                end
                else
                begin
                    stop_next = 1'b1;
                end
            end
            else
            begin
                unique case (mode_reg)
                    qtok_pkg::MODE_WORD:
                    begin
                        if ((qtok_pkg::is_letter(b) || qtok_pkg::is_digit(b))
                            && (tok_reg < {2'b00, cfg.max_word_chars}))
                        begin
                            tok_next = tok_reg + 8'd1;
                        end
                        else
                        begin
                            brk = 1'b1;
                        end
                    end
                    qtok_pkg::MODE_TRAIL:
                    begin
                        if (qtok_pkg::is_trail(b))
                        begin
                            tok_next  = tok_reg + 8'd1;
                            mode_next = qtok_pkg::MODE_GAP;
                        end
                        else
                        begin
                            brk = 1'b1;
                        end
                    end
                    qtok_pkg::MODE_GAP:
                    begin
                        if (qtok_pkg::is_lead(b))
                        begin
                            if (space_reg || (tok_reg >= run_limit))
                            begin
                                brk = 1'b1;
                            end
                            else
                            begin
                                tok_next   = tok_reg + 8'd1;
                                mode_next  = qtok_pkg::MODE_TRAIL;
                                space_next = 1'b0;
                            end
                        end
                        else if (b == qtok_pkg::CH_SPACE)
                        begin
                            space_next = 1'b1;
                        end
                        else if ((b == qtok_pkg::CH_LF) || (b == qtok_pkg::CH_CR))
                        begin
                            space_next = 1'b0;
                        end
                        else
                        begin
                            brk = 1'b1;
                        end
                    end
                    default:
                    begin
                        brk = 1'b0;
                    end
                endcase

                if (brk)
                begin
                    emit_req  = 1'b1;
                    emit_done = eoq;
                    if (eoq)
                    begin
                        clr = 1'b1;
                    end
                    else
                    begin
                        tl_req = 1'b1;
                    end
                end
                else if (eoq)
                begin
                    emit_req  = 1'b1;
                    emit_done = 1'b1;
                    clr       = 1'b1;
                end
            end
        end

        // close the running token
        if (emit_req)
        begin
            kind = (mode_next != qtok_pkg::MODE_WORD);
            len  = kind ? {tok_next[7:1], 1'b0} : tok_next;
            ex   = excl_next;
            done = emit_done;
            hit  = (len != 8'd0);
            mode_next  = qtok_pkg::MODE_IDLE;
            excl_next  = 1'b0;
            tok_next   = '0;
            space_next = 1'b0;
        end

        // fresh handling of a byte outside any token
        if (tl_req)
        begin
            if (qtok_pkg::is_letter(b))
            begin
                mode_next  = qtok_pkg::MODE_WORD;
                tok_next   = 8'd1;
                start_next = here;
                if (tl_eoq)
                begin
                    hit       = 1'b1;
                    kind      = 1'b0;
                    len       = 8'd1;
                    ex        = excl_next;
                    done      = 1'b1;
                    start_sel = here;
                end
            end
            else if (qtok_pkg::is_lead(b))
            begin
                mode_next  = qtok_pkg::MODE_TRAIL;
                tok_next   = 8'd1;
                start_next = here;
                space_next = 1'b0;
            end
            else
            begin
                if ((b >= qtok_pkg::HIGH_MIN) && !tl_eoq)
                begin
                    skip_next = 1'b1;
                end
                if ((b == qtok_pkg::CH_MINUS) && item.search_started)
                begin
                    excl_next = 1'b1;
                end
            end
            if (tl_eoq)
            begin
                clr = 1'b1;
            end
        end

        // end of query clears everything but the registers
        if (clr)
        begin
            mode_next  = qtok_pkg::MODE_IDLE;
            tok_next   = '0;
            start_next = '0;
            pos_next   = '0;
            space_next = 1'b0;
            excl_next  = 1'b0;
            skip_next  = 1'b0;
            stop_next  = 1'b0;
        end
    end

    assign start_ext = {16'h0000, start_sel};

    assign res_valid        = item_valid && hit;
    assign res.token_kind   = kind;
    assign res.token_start  = start_ext[15:0];
    assign res.token_length = len;
    assign res.excluded     = ex;
    assign res.query_done   = done;

endmodule

/* rtl/qtok_out_fifo.sv */
// two-entry result buffer in front of the token port
`timescale 1ns / 1ps

module qtok_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  qtok_pkg::token_t push_data,
    output logic             space,
    output logic             token_valid,
    input  logic             token_stall,
    output qtok_pkg::token_t head
);

    qtok_pkg::token_t slot_reg [2];
    logic [1:0]       count_reg, count_next;
    logic             rd_reg, rd_next;
    logic             wr_reg, wr_next;
    logic             pop;

    assign pop         = token_valid && !token_stall;
    assign space       = (count_reg != 2'd2);
    assign token_valid = (count_reg != 2'd0);
    assign head        = slot_reg[rd_reg];

    // pointer and fill count update
    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
        rd_next    = rd_reg ^ pop;
        wr_next    = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
        end
    end

    // slot write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule

/* rtl/mixed_gb_ascii_query_tokenizer.sv */
// top level of the mixed ascii / double-byte query tokenizer
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one query byte per clock and returns search tokens (ascii words and
// double-byte character runs) on the token port. A byte is accepted each cycle
// while query_stall is low. It sits in the input register while the step logic
// works on it. When the step logic takes it, the tokenizer state updates and any
// token lands in a two-entry result buffer. So a token is offered once its closing
// byte has passed the input register and been written into the result buffer.
// query_stall rises only when the input register holds a byte and both buffer
// slots are full; with the token side never stalling the rate is one byte per
// cycle. No clearing pass after reset. Write max_word_chars (index 0) and
// max_run_bytes (index 1) only while no query byte is in flight.
module mixed_gb_ascii_query_tokenizer #(
    parameter int POS_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // query byte channel
    input  logic        query_valid,
    output logic        query_stall,
    input  logic [7:0]  query_byte,
    input  logic        search_started,
    input  logic        end_of_query,
    // token channel
    output logic        token_valid,
    input  logic        token_stall,
    output logic        token_kind,
    output logic [15:0] token_start,
    output logic [7:0]  token_length,
    output logic        excluded,
    output logic        query_done,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    qtok_pkg::cfg_t   cfg_reg, cfg_next;
    qtok_pkg::item_t  in_item;
    qtok_pkg::item_t  held_item;
    logic             held_valid;
    logic             take;
    logic             space;
    logic             res_valid;
    logic             push;
    qtok_pkg::token_t res;
    qtok_pkg::token_t head;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                qtok_pkg::REG_MAX_WORD_CHARS: cfg_next.max_word_chars = cfg_data[5:0];
                qtok_pkg::REG_MAX_RUN_BYTES:  cfg_next.max_run_bytes  = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_word_chars <= qtok_pkg::MAX_WORD_CHARS_RST;
            cfg_reg.max_run_bytes  <= qtok_pkg::MAX_RUN_BYTES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input register
    assign in_item.query_byte     = query_byte;
    assign in_item.search_started = search_started;
    assign in_item.end_of_query   = end_of_query;

    assign take = held_valid && space;

    qtok_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_valid),
        .query_stall (query_stall),
        .item        (in_item),
        .take        (take),
        .held_valid  (held_valid),
        .held_item   (held_item)
    );

    // tokenizer state and step logic
    qtok_step #(
        .POS_BITS (POS_BITS)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (take),
        .item       (held_item),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result buffer
    assign push = res_valid;

    qtok_out_fifo u_out_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_data   (res),
        .space       (space),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .head        (head)
    );

    assign token_kind   = head.token_kind;
    assign token_start  = head.token_start;
    assign token_length = head.token_length;
    assign excluded     = head.excluded;
    assign query_done   = head.query_done;

    // checks
    `QT_NEVER(a_push_when_full, push && !space, "token pushed into a full result buffer")
    `QT_ASSERT(a_stall_needs_held, query_stall |-> (held_valid && !space),
        "input stalled without a held byte blocked by the result buffer")
    `QT_ASSERT(a_accept_holds, (query_valid && !query_stall) |=> held_valid,
        "accepted query byte missing from the input register")
    `QT_ASSERT(a_token_has_length, push |-> (res.token_length != 8'd0),
        "zero length token produced")

endmodule

/* tb/sv/tb.sv */
// self-checking testbench for the mixed ascii / double-byte query tokenizer
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       query_valid = 1'b0;
    logic       query_stall;
    logic [7:0] query_byte = 8'h00;
    logic       search_started = 1'b0;
    logic       end_of_query = 1'b0;
    logic        token_valid;
    logic        token_stall = 1'b0;
    logic        token_kind;
    logic [15:0] token_start;
    logic [7:0]  token_length;
    logic        excluded;
    logic        query_done;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    qtok_pkg::reg_index_t cfg_index = qtok_pkg::REG_MAX_WORD_CHARS;
    logic [7:0] cfg_data = 8'h00;

    // shared test state
    int         errors = 0;
    int         cycles = 0;
    int         items_sent = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         hold_req = 0;
    qtok_pkg::token_t expected_tokens[$];
    logic [7:0] query_text[$];

    // tokenizer prediction state and register copies
    qtok_pkg::mode_t scan_st = qtok_pkg::MODE_IDLE;
    logic [7:0]  tok_len = '0;
    logic [15:0] tok_first = '0;
    logic [15:0] byte_pos = '0;
    logic        gap_space = 1'b0;
    logic        minus_armed = 1'b0;
    logic        swallow_next = 1'b0;
    logic        halted = 1'b0;
    logic [5:0]  word_lim = qtok_pkg::MAX_WORD_CHARS_RST;
    logic [7:0]  run_lim = qtok_pkg::MAX_RUN_BYTES_RST;

    mixed_gb_ascii_query_tokenizer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .query_valid    (query_valid),
        .query_stall    (query_stall),
        .query_byte     (query_byte),
        .search_started (search_started),
        .end_of_query   (end_of_query),
        .token_valid    (token_valid),
        .token_stall    (token_stall),
        .token_kind     (token_kind),
        .token_start    (token_start),
        .token_length   (token_length),
        .excluded       (excluded),
        .query_done     (query_done),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // byte classes
    function automatic logic alpha_byte(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic logic numeral_byte(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic lead_byte(input logic [7:0] b);
        return b >= qtok_pkg::LEAD_LO && b <= qtok_pkg::LEAD_HI;
    endfunction

    function automatic logic trail_byte(input logic [7:0] b);
        return b >= qtok_pkg::TRAIL_LO && b <= qtok_pkg::TRAIL_HI;
    endfunction

    // clear everything that belongs to one query
    function automatic void restart_query();
        scan_st = qtok_pkg::MODE_IDLE;
        tok_len = '0;
        tok_first = '0;
        byte_pos = '0;
        gap_space = 1'b0;
        minus_armed = 1'b0;
        swallow_next = 1'b0;
        halted = 1'b0;
    endfunction

    // close the open token; runs lose an odd last byte, empty tokens vanish
    function automatic logic close_token(input logic done, output qtok_pkg::token_t tok);
        logic [7:0] len;
        logic       kind;
        logic       ex;
        len = tok_len;
        kind = (scan_st == qtok_pkg::MODE_WORD) ? 1'b0 : 1'b1;
        ex = minus_armed;
        scan_st = qtok_pkg::MODE_IDLE;
        minus_armed = 1'b0;
        tok_len = '0;
        gap_space = 1'b0;
        if (kind)
            len[0] = 1'b0;
        tok.token_kind = kind;
        tok.token_start = tok_first;
        tok.token_length = len;
        tok.excluded = ex;
        tok.query_done = done;
        return len != 8'd0;
    endfunction

    // a nonzero byte seen with no token open
    function automatic logic fresh_byte(input logic [7:0] b, input logic [15:0] here,
                                        input logic ss, input logic eoq,
                                        output qtok_pkg::token_t tok);
        logic got;
        got = 1'b0;
        tok = '0;
        if (alpha_byte(b))
        begin
            scan_st = qtok_pkg::MODE_WORD;
            tok_len = 8'd1;
            tok_first = here;
            if (eoq)
                got = close_token(1'b1, tok);
        end
        else if (lead_byte(b))
        begin
            scan_st = qtok_pkg::MODE_TRAIL;
            tok_len = 8'd1;
            tok_first = here;
            gap_space = 1'b0;
        end
        else
        begin
            if (b >= qtok_pkg::HIGH_MIN && !eoq)
                swallow_next = 1'b1;
            if (b == qtok_pkg::CH_MINUS && ss)
                minus_armed = 1'b1;
        end
        if (eoq)
            restart_query();
        return got;
    endfunction

    // next token state for one accepted byte; returns 1 when a token comes out
    function automatic logic predict_token(input logic [7:0] b, input logic ss,
                                           input logic eoq, output qtok_pkg::token_t tok);
        logic [15:0]      here;
        logic [7:0]       cap;
        logic             brk;
        logic             got;
        qtok_pkg::token_t spare;
        tok = '0;
        got = 1'b0;
        brk = 1'b0;
        cap = (run_lim > qtok_pkg::RUN_CAP) ? qtok_pkg::RUN_CAP : run_lim;
        if (halted)
        begin
            if (eoq)
                restart_query();
            return 1'b0;
        end
        if (swallow_next)
        begin
            swallow_next = 1'b0;
            if (eoq)
                restart_query();
            else if (b == qtok_pkg::CH_NUL)
                halted = 1'b1;
            return 1'b0;
        end
        here = byte_pos;
        byte_pos = byte_pos + 16'd1;
        if (scan_st == qtok_pkg::MODE_IDLE)
        begin
            if (b == qtok_pkg::CH_NUL)
            begin
                if (eoq)
                    restart_query();
                else
                    halted = 1'b1;
                return 1'b0;
            end
            return fresh_byte(b, here, ss, eoq, tok);
        end
        // zero byte closes the open token and the query
        if (b == qtok_pkg::CH_NUL)
        begin
            got = close_token(1'b1, tok);
            if (eoq)
                restart_query();
            else
                halted = 1'b1;
            return got;
        end
        case (scan_st)
            qtok_pkg::MODE_WORD:
                if ((alpha_byte(b) || numeral_byte(b)) && tok_len < {2'b00, word_lim})
                    tok_len = tok_len + 8'd1;
                else
                    brk = 1'b1;
            qtok_pkg::MODE_TRAIL:
                if (trail_byte(b))
                begin
                    tok_len = tok_len + 8'd1;
                    scan_st = qtok_pkg::MODE_GAP;
                end
                else
                    brk = 1'b1;
            default:
                if (lead_byte(b))
                begin
                    if (gap_space || tok_len >= cap)
                        brk = 1'b1;
                    else
                    begin
                        tok_len = tok_len + 8'd1;
                        scan_st = qtok_pkg::MODE_TRAIL;
                        gap_space = 1'b0;
                    end
                end
                else if (b == qtok_pkg::CH_SPACE)
                    gap_space = 1'b1;
                else if (b == qtok_pkg::CH_LF || b == qtok_pkg::CH_CR)
                    gap_space = 1'b0;
                else
                    brk = 1'b1;
        endcase
        // the breaking byte is looked at again unless it ends the query
        if (brk)
        begin
            got = close_token(eoq, tok);
            if (eoq)
                restart_query();
            else
                void'(fresh_byte(b, here, ss, 1'b0, spare));
            return got;
        end
        if (eoq)
        begin
            got = close_token(1'b1, tok);
            restart_query();
        end
        return got;
    endfunction

    function automatic void check_field(input string name, input int want, input int seen);
        if (want != seen)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
            errors++;
        end
    endfunction

    // predict on each accepted byte, compare each accepted token
    always @(posedge clk)
    begin : token_scoreboard
        qtok_pkg::token_t want;
        if (rst_n && query_valid && !query_stall)
            if (predict_token(query_byte, search_started, end_of_query, want))
                expected_tokens.push_back(want);
        if (rst_n && token_valid && !token_stall)
        begin
            if (expected_tokens.size() == 0)
            begin
                $display("%0t: token with none expected: kind %0d start %0d length %0d",
                         $time, token_kind, token_start, token_length);
                errors++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("token_kind", want.token_kind, token_kind);
                check_field("token_start", want.token_start, token_start);
                check_field("token_length", want.token_length, token_length);
                check_field("excluded", want.excluded, excluded);
                check_field("query_done", want.query_done, query_done);
            end
        end
    end

    // token sink: random stalls, plus long hold-offs on request
    initial
    begin : token_sink
        int held;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                held = hold_req;
                hold_req = 0;
                token_stall <= 1'b1;
                repeat (held) @(posedge clk);
            end
            else
                token_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // offer one byte, with random idle cycles first, until it is taken
    task automatic send_byte(input logic [7:0] b, input logic ss, input logic eoq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            query_valid <= 1'b0;
            @(posedge clk);
        end
        query_valid <= 1'b1;
        query_byte <= b;
        search_started <= ss;
        end_of_query <= eoq;
        @(posedge clk);
        while (!(query_valid && !query_stall))
            @(posedge clk);
    endtask

    // send the buffered query, end_of_query on its last byte
    task automatic send_text(input int ss_pct);
        int i;
        for (i = 0; i < query_text.size(); i++)
            send_byte(query_text[i], $urandom_range(99) < ss_pct, i == query_text.size() - 1);
        items_sent += query_text.size();
        query_text.delete();
    endtask

    // stop offering and wait until every token is out and the pipe is empty
    task automatic settle_block();
        query_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write both registers back to back, block idle
    task automatic write_limits(input logic [5:0] words, input logic [7:0] runs);
        cfg_valid <= 1'b1;
        cfg_index <= qtok_pkg::REG_MAX_WORD_CHARS;
        cfg_data <= {2'b00, words};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        word_lim = words;
        cfg_index <= qtok_pkg::REG_MAX_RUN_BYTES;
        cfg_data <= runs;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        run_lim = runs;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_letter();
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
    endfunction

    // one query of words, runs, separators and stray bytes
    task automatic build_random_query();
        int pieces;
        int n;
        int k;
        pieces = $urandom_range(8, 1);
        repeat (pieces)
        begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    // word, sometimes past the length limit
                    n = ($urandom_range(9) == 0) ? $urandom_range(word_lim + 2, 1)
                                                 : $urandom_range(6, 1);
                    query_text.push_back(random_letter());
                    repeat (n - 1)
                        query_text.push_back(($urandom_range(3) == 0)
                                             ? 8'h30 + 8'($urandom_range(9))
                                             : random_letter());
                end
                7, 8, 9, 10, 11, 12:
                begin
                    // double-byte run with optional gap bytes and an odd tail
                    n = ($urandom_range(9) == 0) ? $urandom_range(run_lim / 2 + 2, 1)
                                                 : $urandom_range(4, 1);
                    for (k = 0; k < n; k++)
                    begin
                        if (k > 0 && $urandom_range(99) < 15)
                            case ($urandom_range(3))
                                0: query_text.push_back(qtok_pkg::CH_SPACE);
                                1: query_text.push_back(qtok_pkg::CH_CR);
                                2: query_text.push_back(qtok_pkg::CH_LF);
                                default:
                                begin
                                    query_text.push_back(qtok_pkg::CH_SPACE);
                                    query_text.push_back(qtok_pkg::CH_LF);
                                end
                            endcase
                        query_text.push_back(
                            8'($urandom_range(qtok_pkg::LEAD_HI, qtok_pkg::LEAD_LO)));
                        if (!(k == n - 1 && $urandom_range(99) < 10))
                            query_text.push_back(
                                8'($urandom_range(qtok_pkg::TRAIL_HI, qtok_pkg::TRAIL_LO)));
                    end
                end
                13, 14, 15, 16:
                    case ($urandom_range(6))
                        0: query_text.push_back(qtok_pkg::CH_SPACE);
                        1: query_text.push_back(",");
                        2: query_text.push_back(qtok_pkg::CH_MINUS);
                        3: query_text.push_back(".");
                        4: query_text.push_back(qtok_pkg::CH_CR);
                        5: query_text.push_back(qtok_pkg::CH_LF);
                        default: query_text.push_back("!");
                    endcase
                17, 18:
                begin
                    // non-lead high byte and the byte it swallows
                    query_text.push_back($urandom_range(1) ? 8'($urandom_range(8'hAF, 8'h80))
                                                           : 8'($urandom_range(8'hFF, 8'hF8)));
                    query_text.push_back(($urandom_range(3) == 0) ? qtok_pkg::CH_NUL
                                                                  : 8'($urandom_range(255)));
                end
                default:
                    query_text.push_back(($urandom_range(2) == 0) ? qtok_pkg::CH_NUL
                                                                  : 8'($urandom_range(255)));
            endcase
        end
    endtask

    // words, runs, exclusion, gap bytes, skips, zero stop, eoq cases, reset limits
    task automatic test_directed_cases();
        send_idle_pct = 0;
        stall_pct = 0;
        query_text = '{qtok_pkg::CH_MINUS, "A", "Z", "a", "z", "0", "9", qtok_pkg::CH_SPACE,
                       8'hB0, 8'hA1, qtok_pkg::CH_CR, qtok_pkg::LEAD_HI, qtok_pkg::TRAIL_HI,
                       qtok_pkg::CH_LF, qtok_pkg::CH_SPACE, 8'hB5, qtok_pkg::CH_MINUS,
                       8'hC0, qtok_pkg::HIGH_MIN, "A", "b", 8'hFF};
        send_text(100);
        query_text = '{"z", qtok_pkg::CH_NUL, "q", "x"};
        send_text(100);
        query_text = '{8'h81, "b"};
        send_text(100);
        query_text = '{"a"};
        send_text(0);
        settle_block();
    endtask

    // smallest and largest limits, plus a run limit above the cap
    task automatic test_register_extremes();
        int i;
        write_limits(6'd1, 8'd2);
        query_text = '{"a", "b", "1", "c", qtok_pkg::CH_SPACE, 8'hB0, 8'hA1, 8'hB1, 8'hA2,
                       8'hB2, 8'hA3, "9"};
        send_text(100);
        settle_block();
        write_limits(6'd63, 8'd255);
        query_text.push_back("x");
        for (i = 0; i < 69; i++)
            query_text.push_back((i % 10 == 3) ? 8'h30 + 8'(i % 10) : random_letter());
        query_text.push_back(qtok_pkg::CH_SPACE);
        for (i = 0; i < 128; i++)
        begin
            query_text.push_back(8'($urandom_range(qtok_pkg::LEAD_HI, qtok_pkg::LEAD_LO)));
            query_text.push_back(8'($urandom_range(qtok_pkg::TRAIL_HI, qtok_pkg::TRAIL_LO)));
        end
        send_text(50);
        settle_block();
    endtask

    // long token hold-off while bytes keep coming, so the input stalls
    task automatic test_output_backpressure();
        int i;
        send_idle_pct = 0;
        stall_pct = 0;
        for (i = 0; i < 20; i++)
        begin
            query_text.push_back(random_letter());
            query_text.push_back(qtok_pkg::CH_SPACE);
        end
        hold_req = 80;
        send_text(100);
        settle_block();
    endtask

    // random queries under one idle pattern and one random register setting
    task automatic test_random_traffic(input int idle, input int stall, input int count);
        logic [5:0] words;
        logic [7:0] runs;
        int         first;
        words = ($urandom_range(3) == 0) ? 6'd63 : 6'($urandom_range(12, 1));
        case ($urandom_range(5))
            0: runs = 8'd254;
            1: runs = 8'd255;
            2: runs = 8'd2;
            default: runs = 8'($urandom_range(16, 3));
        endcase
        write_limits(words, runs);
        send_idle_pct = idle;
        stall_pct = stall;
        first = items_sent;
        while (items_sent - first < count)
        begin
            build_random_query();
            case ($urandom_range(2))
                0: send_text(0);
                1: send_text(100);
                default: send_text(70);
            endcase
        end
        settle_block();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic(0, 0, 40);
        test_random_traffic(0, 0, 40);
        test_random_traffic(70, 0, 40);
        test_random_traffic(70, 0, 40);
        test_random_traffic(0, 70, 40);
        test_random_traffic(0, 70, 40);
        test_random_traffic(32, 32, 40);
        test_random_traffic(32, 32, 40);
        settle_block();
        if (errors == 0 && expected_tokens.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
